### rtl/ccsg_pkg.sv
package ccsg_pkg;

    localparam int ROW_COUNT    = 32;
    localparam int COLUMN_COUNT = 512;

    localparam int ADDR_W     = $clog2(ROW_COUNT);
    localparam int CNT_W      = $clog2(COLUMN_COUNT);
    localparam int COL_W      = 9;
    localparam int SPAN_ROW_W = 5;
    localparam int CLIP_W     = 6;
    localparam int VH_W       = 6;
    localparam int LVL_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SKY         = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 1'b1;

    typedef logic signed [LVL_W-1:0] t_lvl;
    typedef logic [COL_W-1:0] t_col;

    typedef struct packed {
        logic              sky;
        logic [VH_W-1:0]   view_height;
    } t_cfg;

    typedef struct packed {
        logic                     last_column;
        logic signed [CLIP_W-1:0] floor_clip;
        logic [CLIP_W-1:0]        ceiling_clip;
    } t_item;

    typedef struct packed {
        logic                  last_span;
        logic                  is_floor;
        t_col                  span_right;
        t_col                  span_left;
        logic [SPAN_ROW_W-1:0] span_row;
    } t_span;

endpackage

### rtl/ccsg_start_ram.sv
module ccsg_start_ram import ccsg_pkg::*; #(
    parameter int DEPTH = ROW_COUNT,
    parameter int WIDTH = COL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ccsg_span_out.sv
module ccsg_span_out import ccsg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_span i_span,
    output logic  o_take,
    input  logic  i_ready,
    output logic  o_valid,
    output t_span o_span
);

    logic  r_valid;
    logic  n_valid;
    t_span r_span;

    assign o_take = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_span <= i_span;
        end
    end

    assign o_valid = r_valid;
    assign o_span  = r_span;

endmodule

### rtl/ccsg_seq.sv
module ccsg_seq import ccsg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_item i_item,
    input  logic  i_out_take,
    output logic  o_push,
    output t_span o_span
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_C_OPEN  = 5'b00010,
        S_C_CLOSE = 5'b00100,
        S_F_OPEN  = 5'b01000,
        S_F_CLOSE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_col, n_col;
    logic [LVL_W-2:0] r_ceil_lvl, n_ceil_lvl;
    logic signed [LVL_W-2:0] r_floor_lvl, n_floor_lvl;

    t_col r_x, n_x, r_xm1, n_xm1;
    logic r_last, n_last, r_sky, n_sky, r_f_any, n_f_any;
    t_lvl r_y, n_y, r_twall, n_twall, r_clow, n_clow;
    t_lvl r_bwall, n_bwall, r_fhigh, n_fhigh, r_fl, n_fl;

    logic r_rd_vld, n_rd_vld;
    logic r_rd_floor, n_rd_floor;
    logic [SPAN_ROW_W-1:0] r_rd_row, n_rd_row;
    t_col r_rd_right, n_rd_right;
    logic r_rd_last, n_rd_last;

    logic [VH_W-1:0] vh;
    t_lvl vh_s, vh_m1, cc, fc, twall, bwall, cl, fl, clow, fhigh, fmin;
    logic x0, is_last, f_any;

    logic push, issue_ok, issue;
    t_lvl y_dn, y_up, raddr_lvl;
    logic c_we, f_we, c_re, f_re;
    t_col c_rdata, f_rdata;

    // Clamp the incoming column's clips against the current view height and derive its levels.
    always_comb begin
        if (i_cfg.view_height == '0) begin
            vh = VH_W'(1);
        end else if (i_cfg.view_height > VH_W'(ROW_COUNT)) begin
            vh = VH_W'(ROW_COUNT);
        end else begin
            vh = i_cfg.view_height;
        end
        vh_s  = {1'b0, vh};
        vh_m1 = vh_s - t_lvl'(1);
        cc    = {1'b0, i_item.ceiling_clip};
        fc    = {i_item.floor_clip[CLIP_W-1], i_item.floor_clip};
        twall = (cc > vh_s) ? vh_s : cc;
        if (fc > vh_m1) begin
            bwall = vh_m1;
        end else if (fc < t_lvl'(-1)) begin
            bwall = t_lvl'(-1);
        end else begin
            bwall = fc;
        end
        x0      = (r_col == '0);
        is_last = i_item.last_column || (r_col == CNT_W'(COLUMN_COUNT - 1));
        cl      = x0 ? t_lvl'(0) : {1'b0, r_ceil_lvl};
        fl      = x0 ? vh_m1 : {r_floor_lvl[LVL_W-2], r_floor_lvl};
        clow    = is_last ? t_lvl'(0) : twall;
        fhigh   = is_last ? vh_m1 : bwall;
        fmin    = (fl < bwall) ? fl : bwall;
        f_any   = (fhigh > fmin);
    end

    assign push     = r_rd_vld && i_out_take;
    assign issue_ok = !r_rd_vld || push;
    assign y_dn     = r_y - t_lvl'(1);
    assign y_up     = r_y + t_lvl'(1);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_ceil_lvl  = r_ceil_lvl;
        n_floor_lvl = r_floor_lvl;
        n_x         = r_x;
        n_xm1       = r_xm1;
        n_last      = r_last;
        n_sky       = r_sky;
        n_f_any     = r_f_any;
        n_y         = r_y;
        n_twall     = r_twall;
        n_clow      = r_clow;
        n_bwall     = r_bwall;
        n_fhigh     = r_fhigh;
        n_fl        = r_fl;
        n_rd_floor  = r_rd_floor;
        n_rd_row    = r_rd_row;
        n_rd_right  = r_rd_right;
        n_rd_last   = r_rd_last;
        issue       = 1'b0;
        c_we        = 1'b0;
        f_we        = 1'b0;
        c_re        = 1'b0;
        f_re        = 1'b0;
        raddr_lvl   = y_dn;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = COL_W'(r_col);
                    n_xm1   = COL_W'(r_col) - t_col'(1);
                    n_last  = is_last;
                    n_sky   = i_cfg.sky;
                    n_f_any = f_any;
                    n_y     = cl;
                    n_twall = twall;
                    n_clow  = clow;
                    n_bwall = bwall;
                    n_fhigh = fhigh;
                    n_fl    = fl;
                    n_state = S_C_OPEN;
                end
            end
            S_C_OPEN: begin
                if (r_y < r_twall) begin
                    c_we = 1'b1;
                    n_y  = y_up;
                end else if (!r_sky && (r_y > r_clow)) begin
                    n_state = S_C_CLOSE;
                end else begin
                    n_y     = r_fl;
                    n_state = S_F_OPEN;
                end
            end
            S_C_CLOSE: begin
                if (issue_ok) begin
                    issue      = 1'b1;
                    c_re       = 1'b1;
                    raddr_lvl  = y_dn;
                    n_rd_floor = 1'b0;
                    n_rd_row   = y_dn[SPAN_ROW_W-1:0];
                    n_rd_right = (y_dn >= r_twall) ? r_xm1 : r_x;
                    n_rd_last  = (y_dn == r_clow) && !r_f_any;
                    if (y_dn == r_clow) begin
                        n_y     = r_fl;
                        n_state = S_F_OPEN;
                    end else begin
                        n_y = y_dn;
                    end
                end
            end
            S_F_OPEN: begin
                if (r_y > r_bwall) begin
                    f_we = 1'b1;
                    n_y  = y_dn;
                end else if (r_y < r_fhigh) begin
                    n_state = S_F_CLOSE;
                end else begin
                    n_ceil_lvl  = r_clow[LVL_W-2:0];
                    n_floor_lvl = r_fhigh[LVL_W-2:0];
                    n_col       = r_last ? '0 : r_col + CNT_W'(1);
                    n_state     = S_IDLE;
                end
            end
            S_F_CLOSE: begin
                if (issue_ok) begin
                    issue      = 1'b1;
                    f_re       = 1'b1;
                    raddr_lvl  = y_up;
                    n_rd_floor = 1'b1;
                    n_rd_row   = y_up[SPAN_ROW_W-1:0];
                    n_rd_right = (y_up <= r_bwall) ? r_xm1 : r_x;
                    n_rd_last  = (y_up == r_fhigh);
                    if (y_up == r_fhigh) begin
                        n_ceil_lvl  = r_clow[LVL_W-2:0];
                        n_floor_lvl = r_fhigh[LVL_W-2:0];
                        n_col       = r_last ? '0 : r_col + CNT_W'(1);
                        n_state     = S_IDLE;
                    end else begin
                        n_y = y_up;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (issue) begin
            n_rd_vld = 1'b1;
        end else if (push) begin
            n_rd_vld = 1'b0;
        end else begin
            n_rd_vld = r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_ceil_lvl  <= '0;
            r_floor_lvl <= (LVL_W-1)'(ROW_COUNT - 1);
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_ceil_lvl  <= n_ceil_lvl;
            r_floor_lvl <= n_floor_lvl;
            r_rd_vld    <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_xm1      <= n_xm1;
        r_last     <= n_last;
        r_sky      <= n_sky;
        r_f_any    <= n_f_any;
        r_y        <= n_y;
        r_twall    <= n_twall;
        r_clow     <= n_clow;
        r_bwall    <= n_bwall;
        r_fhigh    <= n_fhigh;
        r_fl       <= n_fl;
        r_rd_floor <= n_rd_floor;
        r_rd_row   <= n_rd_row;
        r_rd_right <= n_rd_right;
        r_rd_last  <= n_rd_last;
    end

    ccsg_start_ram #(
        .DEPTH (ROW_COUNT),
        .WIDTH (COL_W)
    ) u_ceil_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_y[ADDR_W-1:0]),
        .i_wdata (r_x),
        .i_re    (c_re),
        .i_raddr (raddr_lvl[ADDR_W-1:0]),
        .o_rdata (c_rdata)
    );

    ccsg_start_ram #(
        .DEPTH (ROW_COUNT),
        .WIDTH (COL_W)
    ) u_floor_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (r_y[ADDR_W-1:0]),
        .i_wdata (r_x),
        .i_re    (f_re),
        .i_raddr (raddr_lvl[ADDR_W-1:0]),
        .o_rdata (f_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign o_push     = push;

    always_comb begin
        o_span.last_span  = r_rd_last;
        o_span.is_floor   = r_rd_floor;
        o_span.span_right = r_rd_right;
        o_span.span_left  = r_rd_floor ? f_rdata : c_rdata;
        o_span.span_row   = r_rd_row;
    end

endmodule

### rtl/column_clip_to_span_generator.sv
// Channel  Direction  Handshake             Payload
// s_axis   in         s_axis_tvalid/tready  tdata: ceiling_clip, floor_clip; tlast: last_column
// m_axis   out        m_axis_tvalid/tready  tdata: span_row, span_left, span_right;
//                                           tuser: is_floor; tlast: last_span
// cfg      in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// For one column R start-memory rows are written and S spans are read.
// The sequencer touches one memory entry per cycle; spans leave one per cycle unless stalled.
// Reset is synchronous and active low; it clears the sequencer, the column count and the
// output register; the start memories are not cleared.
// A stalled output holds the sequencer before its next memory read; the next column is taken
// once the current one has issued all of its reads.
module column_clip_to_span_generator import ccsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // ceiling_clip, floor_clip
    input  logic                  s_axis_tlast,   // last_column
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // span_row, span_left, span_right
    output logic                  m_axis_tuser,   // is_floor
    output logic                  m_axis_tlast,   // last_span
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item item;
    t_span seq_span;
    t_span out_span;
    logic  push;
    logic  take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sky         <= 1'b0;
            r_cfg.view_height <= VH_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SKY: begin
                    r_cfg.sky <= i_cfg_data[0];
                end
                CFG_VIEW_HEIGHT: begin
                    r_cfg.view_height <= i_cfg_data[VH_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        item.ceiling_clip = s_axis_tdata[CLIP_W-1:0];
        item.floor_clip   = s_axis_tdata[2*CLIP_W-1:CLIP_W];
        item.last_column  = s_axis_tlast;
    end

    ccsg_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_item     (item),
        .i_out_take (take),
        .o_push     (push),
        .o_span     (seq_span)
    );

    ccsg_span_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_span  (seq_span),
        .o_take  (take),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_span  (out_span)
    );

    assign m_axis_tdata = {1'b0, out_span.span_right, out_span.span_left, out_span.span_row};
    assign m_axis_tuser = out_span.is_floor;
    assign m_axis_tlast = out_span.last_span;

endmodule

### rtl/ccsg_checker.sv
module ccsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second column taken while one is in work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind column_clip_to_span_generator ccsg_checker u_ccsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
